// File: src/cbpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbpa_pkg;

  // Pool geometry
  localparam int MAX_CHUNKS = 8;
  localparam int MAX_BLOCKS = 256;
  localparam int ADDR_W     = 32;

  localparam int CHUNK_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int LINK_DEPTH = MAX_CHUNKS * MAX_BLOCKS;
  localparam int LINK_AW    = CHUNK_W + IDX_W;
  localparam int OPEN_W     = $clog2(MAX_CHUNKS + 1);

  // Field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int USE_W    = 12;
  localparam int LG_W     = 5;
  localparam int BC_W     = 9;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  localparam int LG_MIN = 3;
  localparam int LG_MAX = 16;
  localparam int BLK_W  = ADDR_W - LG_MIN;
  localparam int LIN_W  = LINK_AW;
  localparam int PROD_W = CHUNK_W + BC_W;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

  // Modes
  localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_POOL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_LOG2  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LG_W-1:0]   lg;
    logic [BC_W-1:0]   cnt;
  } cbpa_cfg_t;

endpackage

`default_nettype wire

// File: src/cbpa_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cbpa_cfg_regs
  import cbpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output cbpa_cfg_t               cfg
);

  logic [ADDR_W-1:0] base_r;
  logic [LG_W-1:0]   lg_r;
  logic [BC_W-1:0]   cnt_r;
  logic [1:0]        idx;
  logic              wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      lg_r   <= LG_W'(6);
      cnt_r  <= BC_W'(256);
    end else if (wr_en) begin
      case (idx)
        REG_BASE:  base_r <= pwdata[ADDR_W-1:0];
        REG_LOG2:  lg_r   <= pwdata[LG_W-1:0];
        REG_COUNT: cnt_r  <= pwdata[BC_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE:  prdata = DATA_W'(base_r);
      REG_LOG2:  prdata = DATA_W'(lg_r);
      REG_COUNT: prdata = DATA_W'(cnt_r);
      default:   prdata = '0;
    endcase
  end

  // clamp on use
  always_comb begin
    cfg.base = base_r;
    if (lg_r < LG_W'(LG_MIN))      cfg.lg = LG_W'(LG_MIN);
    else if (lg_r > LG_W'(LG_MAX)) cfg.lg = LG_W'(LG_MAX);
    else                           cfg.lg = lg_r;
    if (cnt_r == '0)                        cfg.cnt = BC_W'(1);
    else if (cnt_r > BC_W'(MAX_BLOCKS))     cfg.cnt = BC_W'(MAX_BLOCKS);
    else                                    cfg.cnt = cnt_r;
  end

endmodule

`default_nettype wire

// File: src/cbpa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cbpa_link_ram
  import cbpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [LINK_AW-1:0] waddr,
  input  wire logic [LINK_W-1:0]  wdata,
  input  wire logic               re,
  input  wire logic [LINK_AW-1:0] raddr,
  output logic      [LINK_W-1:0]  rdata
);

  logic [LINK_W-1:0] mem [LINK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/chunked_block_pool_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size block pool allocator with up to eight chunks, each with its own
// LIFO free list (freed blocks first, then never-used blocks in ascending
// order). A command is taken when start is high and busy is low; busy stays
// high until the command's single result is driven. The result appears on
// out_status / out_block_address / out_blocks_in_use for exactly one cycle
// with out_valid high; there is no back-pressure, so the receiver must take
// it in that cycle. Initialize, shut down and every early error give their
// result straight from S_EXEC; an allocate from never-used blocks then
// passes S_ADDR and S_OUT, and one that pops a freed block first passes
// S_POP for the registered read of the link memory. A free runs a repeated
// subtract-and-compare against the chunk size to find the owning chunk, one
// chunk per cycle, and stops at that chunk (or at the last open chunk when
// the address is outside the pool). The link memory is never cleared:
// entries are only read after a free has written them. Configuration is an
// APB-style port, pready always high; register writes should only be made
// while busy is low.

module chunked_block_pool_allocator_core
  import cbpa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [ADDR_W-1:0]   in_address,
  // result
  output logic                     out_valid,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ADDR_W-1:0]   out_block_address,
  output logic      [USE_W-1:0]    out_blocks_in_use,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,   // decode; finish init, shutdown and early errors
    S_DIV,    // locate owning chunk: subtract chunk size per cycle
    S_POP,    // link read data back, update freed head
    S_ADDR,   // linear block number = chunk * count + index
    S_OUT     // byte address = base + (linear << log2)
  } state_t;

  cbpa_cfg_t cfg;

  cbpa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // link memory controls
  logic               mem_we;
  logic [LINK_AW-1:0] mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [LINK_AW-1:0] mem_raddr;
  logic [LINK_W-1:0]  mem_rdata;

  cbpa_link_ram u_link (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // state
  state_t              state_r,  state_nxt;
  logic [LINK_W-1:0]   head_r  [MAX_CHUNKS];
  logic [LINK_W-1:0]   head_nxt[MAX_CHUNKS];
  logic [LINK_W-1:0]   fresh_r [MAX_CHUNKS];
  logic [LINK_W-1:0]   fresh_nxt[MAX_CHUNKS];
  logic [OPEN_W-1:0]   open_r,   open_nxt;
  logic [USE_W-1:0]    in_use_r, in_use_nxt;
  logic                ready_r,  ready_nxt;

  // per-command working registers
  logic [MODE_W-1:0]   mode_r,   mode_nxt;
  logic [ADDR_W-1:0]   addr_r,   addr_nxt;
  logic [CHUNK_W-1:0]  chunk_r,  chunk_nxt;
  logic [IDX_W-1:0]    idx_r,    idx_nxt;
  logic [BLK_W-1:0]    rem_r,    rem_nxt;
  logic [LIN_W-1:0]    lin_r,    lin_nxt;

  // result registers
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r,   out_addr_nxt;
  logic [USE_W-1:0]    out_use_r,    out_use_nxt;

  // helpers
  logic [CHUNK_W-1:0]  cur_c;
  logic [CHUNK_W-1:0]  new_c;
  logic                cur_empty;
  logic                cur_has_freed;
  logic                pool_full;
  logic [ADDR_W-1:0]   offset;
  logic [ADDR_W-1:0]   blk_full;
  logic                rem_ge;
  logic [OPEN_W-1:0]   q_plus1;
  logic [PROD_W-1:0]   lin_full;

  assign cur_c         = CHUNK_W'(open_r - OPEN_W'(1));
  assign new_c         = CHUNK_W'(open_r);
  assign cur_has_freed = head_r[cur_c] != END_MARK;
  assign cur_empty     = !cur_has_freed && (fresh_r[cur_c] >= LINK_W'(cfg.cnt));
  assign pool_full     = open_r >= OPEN_W'(MAX_CHUNKS);

  assign offset   = addr_r - cfg.base;
  assign blk_full = offset >> cfg.lg;

  // subtract / compare unit for the owning-chunk search
  assign rem_ge  = rem_r >= BLK_W'(cfg.cnt);
  assign q_plus1 = OPEN_W'(chunk_r) + OPEN_W'(1);

  assign lin_full = PROD_W'(chunk_r) * PROD_W'(cfg.cnt) + PROD_W'(idx_r);

  assign mem_raddr = {cur_c, head_r[cur_c][IDX_W-1:0]};
  assign mem_waddr = {chunk_r, rem_r[IDX_W-1:0]};
  assign mem_wdata = head_r[chunk_r];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fresh_nxt      = fresh_r;
    open_nxt       = open_r;
    in_use_nxt     = in_use_r;
    ready_nxt      = ready_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    chunk_nxt      = chunk_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    lin_nxt        = lin_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_use_nxt    = out_use_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          addr_nxt  = in_address;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_addr_nxt = '0;
        if (mode_r == MODE_INIT || mode_r == MODE_SHUTDOWN) begin
          for (int k = 0; k < MAX_CHUNKS; k++) begin
            head_nxt[k]  = END_MARK;
            fresh_nxt[k] = '0;
          end
          open_nxt       = (mode_r == MODE_INIT) ? OPEN_W'(1) : '0;
          ready_nxt      = (mode_r == MODE_INIT);
          in_use_nxt     = '0;
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!ready_r || open_r == '0) begin
          out_status_nxt = ST_NOT_INIT;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (mode_r == MODE_ALLOC) begin
          if (cur_empty && pool_full) begin
            out_status_nxt = ST_EXHAUSTED;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            if (in_use_r != '1) in_use_nxt = in_use_r + USE_W'(1);
            if (cur_empty) begin
              // open a new chunk, first never-used block
              chunk_nxt        = new_c;
              idx_nxt          = '0;
              head_nxt[new_c]  = END_MARK;
              fresh_nxt[new_c] = LINK_W'(1);
              open_nxt         = open_r + OPEN_W'(1);
              state_nxt        = S_ADDR;
            end else if (cur_has_freed) begin
              chunk_nxt = cur_c;
              idx_nxt   = head_r[cur_c][IDX_W-1:0];
              mem_re    = 1'b1;
              state_nxt = S_POP;
            end else begin
              chunk_nxt        = cur_c;
              idx_nxt          = fresh_r[cur_c][IDX_W-1:0];
              fresh_nxt[cur_c] = fresh_r[cur_c] + LINK_W'(1);
              state_nxt        = S_ADDR;
            end
          end
        end else begin
          if (addr_r == '0) begin
            out_status_nxt = ST_NULL;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            rem_nxt   = blk_full[BLK_W-1:0];
            chunk_nxt = '0;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (!rem_ge) begin
          // owner found: push block on its freed list
          mem_we            = 1'b1;
          head_nxt[chunk_r] = LINK_W'(rem_r[IDX_W-1:0]);
          if (in_use_r != '0) in_use_nxt = in_use_r - USE_W'(1);
          out_status_nxt    = ST_OK;
          out_addr_nxt      = '0;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else if (q_plus1 >= open_r) begin
          out_status_nxt = ST_NOT_POOL;
          out_addr_nxt   = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          rem_nxt   = rem_r - BLK_W'(cfg.cnt);
          chunk_nxt = chunk_r + CHUNK_W'(1);
        end
      end

      S_POP: begin
        head_nxt[chunk_r] = mem_rdata;
        state_nxt         = S_ADDR;
      end

      S_ADDR: begin
        lin_nxt   = lin_full[LIN_W-1:0];
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_status_nxt = ST_OK;
        out_addr_nxt   = cfg.base + (ADDR_W'(lin_r) << cfg.lg);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (out_valid_nxt) out_use_nxt = in_use_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      in_use_r    <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_CHUNKS; k++) begin
        head_r[k]  <= END_MARK;
        fresh_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      in_use_r    <= in_use_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
    end
    mode_r       <= mode_nxt;
    addr_r       <= addr_nxt;
    chunk_r      <= chunk_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    lin_r        <= lin_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_use_r    <= out_use_nxt;
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_blocks_in_use = out_use_r;

endmodule

`default_nettype wire

// File: src/cbpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cbpa_checker
  import cbpa_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [ADDR_W-1:0]   out_block_address
);

  // a command transfer always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // a result only follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without preceding command");

  // every command ends with a result
  a_busy_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("command finished without result");

  // a failed command carries a zero address
  a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == '0)
    else $error("nonzero address on failed command");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EXHAUSTED)
    else $error("undefined status code");

endmodule

bind chunked_block_pool_allocator_core cbpa_checker u_cbpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_block_address (out_block_address)
);

`default_nettype wire
